// ----- rtl/core/shp_pkg.sv -----
// Shared types and constants for the 3x3 sharpening byte-stream filter.
`default_nettype none

package shp_pkg;

  // Widths fixed by the stream and the register map
  localparam int unsigned PIX_W       = 8;
  localparam int unsigned ROW_BYTES_W = 14;

  // Register reset value and kernel constants
  localparam logic [ROW_BYTES_W-1:0] ROW_BYTES_RESET = 14'd1920;
  localparam int unsigned            KERNEL_CENTRE   = 9;
  localparam logic [PIX_W-1:0]       PIX_MAX         = 8'd255;

  // Control from the pipeline to the tap window
  typedef struct packed {
    logic shift_rows01;  // a transaction leaves stage 1: shift rows 0 and 1
    logic shift_row2;    // a transaction leaves stage 2: shift row 2
    logic row_zero;      // row length of zero: all rows are the same stream
  } shp_tap_ctrl_t;

endpackage : shp_pkg

`default_nettype wire

// ----- rtl/core/shp_ram.sv -----
// Generic simple dual-port RAM, read-first, with registered read data.
`default_nettype none

module shp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8192
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Read old contents on a same-address write
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  assign rdata_o = rdata_q;

endmodule : shp_ram

`default_nettype wire

// ----- rtl/core/shp_window.sv -----
// Three-row tap window and sharpening kernel with saturation.
`default_nettype none

module shp_window
  import shp_pkg::*;
#(
  parameter int unsigned STRIDE = 3
) (
  input  wire logic          clk_i,
  input  wire shp_tap_ctrl_t ctrl_i,
  input  wire logic [PIX_W-1:0] row0_byte_i,  // newest byte, stage 1
  input  wire logic [PIX_W-1:0] row1_byte_i,  // byte one row back, stage 1
  input  wire logic [PIX_W-1:0] row2_mem_i,   // byte two rows back, stage 2
  output logic      [PIX_W-1:0] pixel_o
);

  localparam int unsigned TAPS = 2 * STRIDE + 1;

  logic [PIX_W-1:0] row0_q [TAPS];
  logic [PIX_W-1:0] row1_q [TAPS];
  logic [PIX_W-1:0] row2_q [TAPS-1];
  logic [PIX_W-1:0] row2_new;

  logic [PIX_W+3:0]        centre9;
  logic [PIX_W+2:0]        neigh_sum;
  logic signed [PIX_W+4:0] acc;

  // Newest byte of the far row: straight from the near row when rows coincide
  assign row2_new = ctrl_i.row_zero ? row1_q[0] : row2_mem_i;

  // Advance the near rows with each transaction leaving stage 1
  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift_rows01) begin
      row0_q[0] <= row0_byte_i;
      row1_q[0] <= row1_byte_i;
      for (int k = 1; k < TAPS; k++) begin
        row0_q[k] <= row0_q[k-1];
        row1_q[k] <= row1_q[k-1];
      end
    end
  end

  // Advance the far row with each transaction leaving stage 2
  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift_row2) begin
      row2_q[0] <= row2_new;
      for (int k = 1; k < TAPS - 1; k++) begin
        row2_q[k] <= row2_q[k-1];
      end
    end
  end

  // Centre weight nine, eight neighbours weight minus one
  always_comb begin
    centre9   = (PIX_W+4)'(row1_q[STRIDE]) * (PIX_W+4)'(KERNEL_CENTRE);
    neigh_sum = (PIX_W+3)'(row0_q[0]) + (PIX_W+3)'(row0_q[STRIDE])
              + (PIX_W+3)'(row0_q[2*STRIDE]) + (PIX_W+3)'(row1_q[0])
              + (PIX_W+3)'(row1_q[2*STRIDE]) + (PIX_W+3)'(row2_new)
              + (PIX_W+3)'(row2_q[STRIDE-1]) + (PIX_W+3)'(row2_q[2*STRIDE-1]);
    acc       = $signed({1'b0, centre9}) - $signed({2'b00, neigh_sum});
  end

  // Clamp to the byte range
  always_comb begin
    if (acc < 0) begin
      pixel_o = '0;
    end else if (acc > $signed({5'b0_0000, PIX_MAX})) begin
      pixel_o = PIX_MAX;
    end else begin
      pixel_o = acc[PIX_W-1:0];
    end
  end

endmodule : shp_window

`default_nettype wire

// ----- rtl/core/sharpen_3x3_byte_stream.sv -----
// Top level of the 3x3 sharpening filter on an interleaved colour byte stream.
//
//  channel  | handshake                       | payload
//  ---------+---------------------------------+---------------------------
//  input    | pixel_valid_i / pixel_stall_o   | pixel_in_i, frame_start_i
//  result   | result_valid_o / result_stall_i | pixel_out_o
//  config   | row_bytes_we_i                  | row_bytes_i
//
// One byte is taken every clock while the result register can move, else the
// input stalls. The rate is set by the two row RAMs, each written and read
// once per transaction. Row delays live in two RAMs of MAX_ROW_BYTES bytes,
// chained; the column taps are short shift registers.
// Reset clears control state only; RAM contents are undefined and feed no
// result before being written in the current fill, so there is no clearing
// pass. A stalled result freezes the whole pipeline and stalls the input.
`default_nettype none

module sharpen_3x3_byte_stream
  import shp_pkg::*;
#(
  parameter int unsigned MAX_ROW_BYTES  = 8192,
  parameter int unsigned CHANNEL_STRIDE = 3
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // Configuration
  input  wire logic                   row_bytes_we_i,
  input  wire logic [ROW_BYTES_W-1:0] row_bytes_i,
  // Input stream
  input  wire logic                   pixel_valid_i,
  output logic                        pixel_stall_o,
  input  wire logic [PIX_W-1:0]       pixel_in_i,
  input  wire logic                   frame_start_i,
  // Result stream
  output logic                        result_valid_o,
  input  wire logic                   result_stall_i,
  output logic      [PIX_W-1:0]       pixel_out_o
);

  localparam int unsigned AW      = $clog2(MAX_ROW_BYTES);
  localparam int unsigned RW      = $clog2(MAX_ROW_BYTES + 1);
  localparam int unsigned WIN_MAX = 2 * MAX_ROW_BYTES + 2 * CHANNEL_STRIDE + 1;
  localparam int unsigned FCW     = $clog2(WIN_MAX + 1);

  // Address a full row back in a circular buffer of MAX_ROW_BYTES entries
  function automatic logic [AW-1:0] row_back(input logic [AW-1:0] p,
                                             input logic [RW-1:0] w);
    logic [RW:0] s;
    s = (RW+1)'(p) + (RW+1)'(MAX_ROW_BYTES) - (RW+1)'(w);
    if (s >= (RW+1)'(MAX_ROW_BYTES)) begin
      s = s - (RW+1)'(MAX_ROW_BYTES);
    end
    return s[AW-1:0];
  endfunction

  logic [ROW_BYTES_W-1:0] row_bytes_q;
  logic [RW-1:0]          row_eff;
  logic [FCW-1:0]         win;
  logic                   row_zero;

  logic [AW-1:0]  ptr_q, ptr_d;
  logic [FCW-1:0] fill_q, fill_d;
  logic [FCW-1:0] fill_base;
  logic           fill_full;

  logic             adv;
  logic             in_xfer;
  logic             mv1;
  logic             mv2;

  logic             v1_q, v2_q;
  logic             res1_q, res2_q;
  logic [PIX_W-1:0] x1_q;
  logic [AW-1:0]    ptr1_q;

  logic [PIX_W-1:0] row1_rd;
  logic [PIX_W-1:0] row1_byte;
  logic [PIX_W-1:0] row2_rd;
  logic [PIX_W-1:0] kernel_pix;

  logic             out_valid_q;
  logic [PIX_W-1:0] pixel_out_q;

  shp_tap_ctrl_t tap_ctrl;

  // Clamp the row length and derive the window length
  always_comb begin
    if ({18'd0, row_bytes_q} > 32'(MAX_ROW_BYTES)) begin
      row_eff = RW'(MAX_ROW_BYTES);
    end else begin
      row_eff = RW'(row_bytes_q);
    end
    win      = FCW'({row_eff, 1'b0}) + FCW'(2 * CHANNEL_STRIDE + 1);
    row_zero = (row_eff == '0);
  end

  // Advance the whole pipeline whenever the result register can move
  assign adv           = !out_valid_q || !result_stall_i;
  assign pixel_stall_o = !adv;
  assign in_xfer       = pixel_valid_i && adv;
  assign mv1           = v1_q && adv;
  assign mv2           = v2_q && adv;

  // Count bytes since the fill began, saturating at the window length
  always_comb begin
    fill_base = frame_start_i ? '0 : fill_q;
    fill_d    = (fill_base < win) ? fill_base + FCW'(1) : fill_base;
    fill_full = (fill_d >= win);
    ptr_d     = (ptr_q == AW'(MAX_ROW_BYTES - 1)) ? '0 : ptr_q + AW'(1);
  end

  // Hold the row register, write pointer and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_bytes_q <= ROW_BYTES_RESET;
      fill_q      <= '0;
      ptr_q       <= '0;
    end else begin
      if (row_bytes_we_i) begin
        row_bytes_q <= row_bytes_i;
        fill_q      <= '0;
      end else if (in_xfer) begin
        fill_q <= fill_d;
      end
      if (in_xfer) begin
        ptr_q <= ptr_d;
      end
    end
  end

  // Stage valids and result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      v1_q        <= in_xfer;
      v2_q        <= v1_q;
      out_valid_q <= v2_q && res2_q;
    end
  end

  // Stage payloads
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      x1_q   <= pixel_in_i;
      ptr1_q <= ptr_q;
      res1_q <= fill_full;
    end
    if (mv1) begin
      res2_q <= res1_q;
    end
    if (mv2) begin
      pixel_out_q <= kernel_pix;
    end
  end

  // First row delay: newest bytes in, bytes one row old out
  shp_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_ROW_BYTES)
  ) u_row1_ram (
    .clk_i   (clk_i),
    .we_i    (in_xfer),
    .waddr_i (ptr_q),
    .wdata_i (pixel_in_i),
    .re_i    (in_xfer),
    .raddr_i (row_back(ptr_q, row_eff)),
    .rdata_o (row1_rd)
  );

  // Forward the newest byte when the row length is zero
  assign row1_byte = row_zero ? x1_q : row1_rd;

  // Second row delay: chained on the output of the first
  shp_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_ROW_BYTES)
  ) u_row2_ram (
    .clk_i   (clk_i),
    .we_i    (mv1),
    .waddr_i (ptr1_q),
    .wdata_i (row1_byte),
    .re_i    (mv1),
    .raddr_i (row_back(ptr1_q, row_eff)),
    .rdata_o (row2_rd)
  );

  assign tap_ctrl = '{shift_rows01: mv1, shift_row2: mv2, row_zero: row_zero};

  shp_window #(
    .STRIDE (CHANNEL_STRIDE)
  ) u_window (
    .clk_i       (clk_i),
    .ctrl_i      (tap_ctrl),
    .row0_byte_i (x1_q),
    .row1_byte_i (row1_byte),
    .row2_mem_i  (row2_rd),
    .pixel_o     (kernel_pix)
  );

  assign result_valid_o = out_valid_q;
  assign pixel_out_o    = pixel_out_q;

endmodule : sharpen_3x3_byte_stream

`default_nettype wire

// ----- rtl/core/shp_chk.sv -----
// Port-level assertions for the sharpening filter, bound to the top level.
`default_nettype none

module shp_chk (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       pixel_stall_o,
  input wire logic       result_valid_o,
  input wire logic       result_stall_i,
  input wire logic [7:0] pixel_out_o
);

  // Hold a stalled result transaction
  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_stall_i) |=> (result_valid_o && $stable(pixel_out_o)))
    else $error("stalled result transaction changed or dropped");

  // Stall the input only behind a blocked result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pixel_stall_o |-> (result_valid_o && result_stall_i))
    else $error("input stalled while the result register was free");

  // Load a new result only on a cycle the pipeline advanced
  a_new_needs_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !$past(result_valid_o && result_stall_i)) |-> !$past(pixel_stall_o))
    else $error("new result appeared without the pipeline advancing");

  // Keep the result channel quiet for the pipeline depth after reset
  a_reset_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> (!result_valid_o ##1 !result_valid_o ##1 !result_valid_o))
    else $error("result transaction too soon after reset");

endmodule : shp_chk

bind sharpen_3x3_byte_stream shp_chk u_shp_chk (.*);

`default_nettype wire
